@@ design/tuvr_pkg.sv @@
// ----------------------------------------------------------------------------
// tuvr_pkg
// Types, constants and the arctangent table shared by the tunnel uv ray marcher.
// ----------------------------------------------------------------------------
package tuvr_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_N      = 24;
    localparam int REFINE_ROUNDS = 16;
    localparam int SINE_SHIFT    = 30 - 4 - FRAC_BITS;
    localparam int TH_SHIFT      = 23 - FRAC_BITS;

    localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
    localparam logic signed [33:0] TURN_QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] TURN_HALF    = 34'sd2147483648;

    typedef struct packed {
        logic [10:0] col;
        logic [10:0] row;
    } t_in_item;

    typedef struct packed {
        logic [7:0] u_coord;
        logic [7:0] v_coord;
    } t_out_item;

    typedef enum logic [1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_THRESH,
        CFG_DEPTH
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_SQRT,
        S_DIV,
        S_TZ,
        S_CORD,
        S_CEN,
        S_TAB,
        S_TSQ0,
        S_TSQ1,
        S_TCMP,
        S_STEP,
        S_BACK,
        S_FIN,
        S_FANG,
        S_FROT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        JOB_TUBE,
        JOB_FINAL,
        JOB_ANGLE
    } t_cjob;

    // arctangent of 2^-k in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

@@ design/tunnel_uv_raymarch.sv @@
// ----------------------------------------------------------------------------
// tunnel_uv_raymarch
// Per-pixel tunnel texture coordinates by fixed-point ray marching.
// ----------------------------------------------------------------------------
// Usage: drive i_in (col, row) and raise i_start; the transaction is taken at
// an edge where i_start is high and o_busy is low. o_busy stays high until the
// result is ready. The result appears on o_result for exactly one cycle with
// o_valid high; the receiver cannot stall it, and a new start can be taken in
// that same cycle. Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) is written
// at an edge where i_cfg_we is high and must only change while o_busy is low.
// Sequence: squaring, square root (one root bit per cycle), division (three
// step components, 22 quotient bits each), then per wall test: setup, the
// shared CORDIC unit for the hole centre sine, centre, range check, the shared
// squarer, compare, then the step or back-off; a test stopped by the depth
// limit goes from setup to the back-off, one stopped by the range check skips
// the squarer and compare. Tests = march steps + refinement rounds (at most
// 16). The final centre and arctangent follow (no arctangent when the hit
// point is at the centre); the strobe is registered from the done state.
// One item at a time; the CORDIC iterations dominate the run time.
// Reset (synchronous, active low) returns the sequencer to idle and loads
// the default screen 320x200, threshold 128 and depth limit 1024.
// ----------------------------------------------------------------------------
module tunnel_uv_raymarch (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tuvr_pkg::t_in_item   i_in,
    output logic                 o_busy,
    output logic                 o_valid,
    output tuvr_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    // configuration
    logic [11:0] r_width, r_height, r_dl;
    logic [15:0] r_thr;

    tuvr_pkg::t_state r_state, n_state;
    tuvr_pkg::t_cjob  r_job;

    logic signed [11:0] r_i, r_j;
    logic [11:0]        r_h;
    logic [23:0]        r_ea, r_eb;
    logic [47:0]        r_prod;
    logic [48:0]        r_acc;
    logic [57:0]        r_nsh;
    logic [30:0]        r_rem;
    logic [28:0]        r_root;
    logic [21:0]        r_q;
    logic [1:0]         r_dsel;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_x, r_y, r_z, r_dx, r_dy, r_dz, r_c;
    logic [3:0]         r_round;
    logic signed [35:0] r_cx, r_cy;
    logic signed [33:0] r_ca;
    logic [4:0]         r_k;
    logic               r_vec;
    logic               r_valid;
    tuvr_pkg::t_out_item r_out;

    function automatic logic [11:0] abs12(input logic signed [11:0] v);
        return v[11] ? 12'(-v) : 12'(v);
    endfunction

    function automatic logic [16:0] mul20(input logic [11:0] v);
        return 17'({v, 4'b0}) + 17'({v, 2'b0});
    endfunction

    function automatic logic signed [31:0] half_tz(input logic signed [31:0] v);
        logic signed [31:0] s;
        s = v + {31'b0, v[31]};
        return s >>> 1;
    endfunction

    function automatic logic signed [31:0] signq(input logic [21:0] q, input logic neg);
        return neg ? -$signed({10'b0, q}) : $signed({10'b0, q});
    endfunction

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd320;
            r_height <= 12'd200;
            r_thr    <= 16'd128;
            r_dl     <= 12'd1024;
        end else if (i_cfg_we) begin
            unique case (tuvr_pkg::t_cfg_idx'(i_cfg_idx))
                tuvr_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[11:0];
                tuvr_pkg::CFG_HEIGHT: r_height <= i_cfg_data[11:0];
                tuvr_pkg::CFG_THRESH: r_thr    <= i_cfg_data;
                tuvr_pkg::CFG_DEPTH:  r_dl     <= i_cfg_data[11:0];
            endcase
        end
    end

    // ---------------- shared squarer ----------------
    logic [23:0] w_sq_op;
    logic [47:0] w_prod;
    always_comb begin
        unique case (r_state)
            tuvr_pkg::S_SQ0:  w_sq_op = {12'b0, abs12(r_i)};
            tuvr_pkg::S_SQ1:  w_sq_op = {12'b0, abs12(r_j)};
            tuvr_pkg::S_SQ2:  w_sq_op = {12'b0, r_h};
            tuvr_pkg::S_TSQ0: w_sq_op = r_ea;
            tuvr_pkg::S_TSQ1: w_sq_op = r_eb;
            default:          w_sq_op = 24'b0;
        endcase
    end
    assign w_prod = w_sq_op * w_sq_op;

    logic [48:0] w_ssum;
    logic [24:0] w_s;
    logic        w_inside;
    assign w_ssum   = r_acc + {1'b0, r_prod};
    assign w_s      = w_ssum[24:0];
    assign w_inside = ({1'b0, r_prod} + r_acc) < {1'b0, r_thr, 32'b0};

    // ---------------- square root / divide step ----------------
    logic [32:0] w_rem4, w_trial;
    logic        w_sge;
    logic [30:0] w_srem;
    logic [28:0] w_sroot;
    assign w_rem4  = {r_rem, r_nsh[57:56]};
    assign w_trial = {2'b0, r_root, 2'b01};
    assign w_sge   = w_rem4 >= w_trial;
    assign w_srem  = w_sge ? 31'(w_rem4 - w_trial) : 31'(w_rem4);
    assign w_sroot = {r_root[27:0], w_sge};

    logic [30:0] w_rem2, w_drem;
    logic        w_dge;
    logic [21:0] w_dq;
    assign w_rem2 = {r_rem[29:0], 1'b0};
    assign w_dge  = w_rem2 >= {2'b0, r_root};
    assign w_drem = w_dge ? (w_rem2 - {2'b0, r_root}) : w_rem2;
    assign w_dq   = {r_q[20:0], w_dge};

    logic [16:0] w_mag_j, w_mag_h;
    assign w_mag_j = mul20(abs12(r_j));
    assign w_mag_h = mul20(r_h);

    // ---------------- shared CORDIC step ----------------
    logic signed [35:0] w_xs, w_ys, w_ncx, w_ncy;
    logic signed [33:0] w_t, w_nca;
    logic               w_sigma;
    assign w_xs    = r_cx >>> r_k;
    assign w_ys    = r_cy >>> r_k;
    assign w_t     = $signed({2'b0, tuvr_pkg::atan_turn(r_k)});
    assign w_sigma = r_vec ? (r_cy[35] || (r_cy == 36'sd0)) : !r_ca[33];
    assign w_ncx   = w_sigma ? (r_cx - w_ys) : (r_cx + w_ys);
    assign w_ncy   = w_sigma ? (r_cy + w_xs) : (r_cy - w_xs);
    assign w_nca   = w_sigma ? (r_ca - w_t) : (r_ca + w_t);

    // sine angle from depth, folded into the right half plane
    logic [31:0]        w_th;
    logic signed [33:0] w_a0, w_afold;
    assign w_th = 32'(r_z) << tuvr_pkg::TH_SHIFT;
    assign w_a0 = $signed({{2{w_th[31]}}, w_th});
    always_comb begin
        priority if (w_a0 > tuvr_pkg::TURN_QUARTER) begin
            w_afold = tuvr_pkg::TURN_HALF - w_a0;
        end else if (w_a0 < -tuvr_pkg::TURN_QUARTER) begin
            w_afold = -tuvr_pkg::TURN_HALF - w_a0;
        end else begin
            w_afold = w_a0;
        end
    end

    logic signed [35:0] w_cys;
    assign w_cys = r_cy >>> tuvr_pkg::SINE_SHIFT;

    // offsets from the hole centre
    logic signed [31:0] w_ex, w_ey, w_zlim;
    logic [31:0]        w_ax, w_ay;
    logic               w_far, w_zout;
    assign w_ex   = r_x - r_c;
    assign w_ey   = r_y - r_c;
    assign w_ax   = w_ex[31] ? 32'(-w_ex) : 32'(w_ex);
    assign w_ay   = w_ey[31] ? 32'(-w_ey) : 32'(w_ey);
    assign w_far  = (w_ax[31:24] != 8'b0) || (w_ay[31:24] != 8'b0);
    assign w_zlim = $signed(32'(r_dl) << tuvr_pkg::FRAC_BITS);
    assign w_zout = r_z >= w_zlim;

    logic signed [31:0] w_hdz;
    assign w_hdz = half_tz(r_dz);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tuvr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tuvr_pkg::S_IDLE: if (i_start) n_state = tuvr_pkg::S_SQ0;
            tuvr_pkg::S_SQ0:  n_state = tuvr_pkg::S_SQ1;
            tuvr_pkg::S_SQ1:  n_state = tuvr_pkg::S_SQ2;
            tuvr_pkg::S_SQ2:  n_state = tuvr_pkg::S_SQ3;
            tuvr_pkg::S_SQ3:  n_state = tuvr_pkg::S_SQRT;
            tuvr_pkg::S_SQRT: if (r_cnt == 5'd0) n_state = tuvr_pkg::S_DIV;
            tuvr_pkg::S_DIV: begin
                if (r_cnt == 5'd0 && r_dsel == 2'd2) begin
                    n_state = (w_dq == 22'd0) ? tuvr_pkg::S_FIN : tuvr_pkg::S_TZ;
                end
            end
            tuvr_pkg::S_TZ:   n_state = w_zout ? tuvr_pkg::S_BACK : tuvr_pkg::S_CORD;
            tuvr_pkg::S_CORD: begin
                if (r_k == 5'(tuvr_pkg::CORDIC_N - 1)) begin
                    n_state = (r_job == tuvr_pkg::JOB_ANGLE) ? tuvr_pkg::S_DONE
                                                             : tuvr_pkg::S_CEN;
                end
            end
            tuvr_pkg::S_CEN: begin
                n_state = (r_job == tuvr_pkg::JOB_TUBE) ? tuvr_pkg::S_TAB : tuvr_pkg::S_FANG;
            end
            tuvr_pkg::S_TAB:  n_state = w_far ? tuvr_pkg::S_BACK : tuvr_pkg::S_TSQ0;
            tuvr_pkg::S_TSQ0: n_state = tuvr_pkg::S_TSQ1;
            tuvr_pkg::S_TSQ1: n_state = tuvr_pkg::S_TCMP;
            tuvr_pkg::S_TCMP: n_state = w_inside ? tuvr_pkg::S_STEP : tuvr_pkg::S_BACK;
            tuvr_pkg::S_STEP: n_state = tuvr_pkg::S_TZ;
            tuvr_pkg::S_BACK: begin
                if (r_round == 4'(tuvr_pkg::REFINE_ROUNDS - 1) || w_hdz == 32'sd0) begin
                    n_state = tuvr_pkg::S_FIN;
                end else begin
                    n_state = tuvr_pkg::S_TZ;
                end
            end
            tuvr_pkg::S_FIN:  n_state = tuvr_pkg::S_CORD;
            tuvr_pkg::S_FANG: n_state = tuvr_pkg::S_FROT;
            tuvr_pkg::S_FROT: begin
                n_state = (r_cx == 36'sd0 && r_cy == 36'sd0) ? tuvr_pkg::S_DONE
                                                             : tuvr_pkg::S_CORD;
            end
            tuvr_pkg::S_DONE: n_state = tuvr_pkg::S_IDLE;
            default:          n_state = tuvr_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            tuvr_pkg::S_IDLE: begin
                r_i <= $signed({1'b0, i_in.col} - {1'b0, r_width[11:1]});
                r_j <= $signed({1'b0, i_in.row} - {1'b0, r_height[11:1]});
                r_h <= (r_height == 12'd0) ? 12'd1 : r_height;
            end
            tuvr_pkg::S_SQ0: r_acc <= 49'd0;
            tuvr_pkg::S_SQ1: r_acc <= w_ssum;
            tuvr_pkg::S_SQ2: r_acc <= w_ssum;
            tuvr_pkg::S_SQ3: begin
                r_nsh  <= {1'b0, w_s, 32'b0};
                r_rem  <= 31'd0;
                r_root <= 29'd0;
                r_cnt  <= 5'd28;
            end
            tuvr_pkg::S_SQRT: begin
                r_nsh  <= {r_nsh[55:0], 2'b0};
                r_root <= w_sroot;
                if (r_cnt == 5'd0) begin
                    r_rem  <= {4'b0, mul20(abs12(r_i)), 10'b0};
                    r_cnt  <= 5'd21;
                    r_dsel <= 2'd0;
                end else begin
                    r_rem <= w_srem;
                    r_cnt <= r_cnt - 5'd1;
                end
            end
            tuvr_pkg::S_DIV: begin
                r_q <= w_dq;
                if (r_cnt == 5'd0) begin
                    r_cnt  <= 5'd21;
                    r_dsel <= r_dsel + 2'd1;
                    unique case (r_dsel)
                        2'd0: begin
                            r_dx  <= signq(w_dq, r_i[11]);
                            r_rem <= {4'b0, w_mag_j, 10'b0};
                        end
                        2'd1: begin
                            // vertical axis points up
                            r_dy  <= signq(w_dq, (r_j != 12'sd0) && !r_j[11]);
                            r_rem <= {4'b0, w_mag_h, 10'b0};
                        end
                        default: begin
                            r_rem   <= w_drem;
                            r_dz    <= signq(w_dq, 1'b0);
                            r_x     <= 32'sd0;
                            r_y     <= 32'sd0;
                            r_z     <= 32'sd0;
                            r_round <= 4'd0;
                        end
                    endcase
                end else begin
                    r_rem <= w_drem;
                    r_cnt <= r_cnt - 5'd1;
                end
            end
            tuvr_pkg::S_TZ: begin
                r_ca  <= w_afold;
                r_cx  <= 36'(tuvr_pkg::CORDIC_K_Q30);
                r_cy  <= 36'sd0;
                r_k   <= 5'd0;
                r_vec <= 1'b0;
                r_job <= tuvr_pkg::JOB_TUBE;
            end
            tuvr_pkg::S_CORD: begin
                r_cx <= w_ncx;
                r_cy <= w_ncy;
                r_ca <= w_nca;
                r_k  <= r_k + 5'd1;
            end
            tuvr_pkg::S_CEN: r_c <= 32'(-w_cys);
            tuvr_pkg::S_TAB: begin
                r_ea <= w_ax[23:0];
                r_eb <= w_ay[23:0];
            end
            tuvr_pkg::S_TSQ1: r_acc <= {1'b0, r_prod};
            tuvr_pkg::S_STEP: begin
                r_x <= r_x + r_dx;
                r_y <= r_y + r_dy;
                r_z <= r_z + r_dz;
            end
            tuvr_pkg::S_BACK: begin
                r_x     <= r_x - r_dx;
                r_y     <= r_y - r_dy;
                r_z     <= r_z - r_dz;
                r_dx    <= half_tz(r_dx);
                r_dy    <= half_tz(r_dy);
                r_dz    <= w_hdz;
                r_round <= r_round + 4'd1;
            end
            tuvr_pkg::S_FIN: begin
                r_ca  <= w_afold;
                r_cx  <= 36'(tuvr_pkg::CORDIC_K_Q30);
                r_cy  <= 36'sd0;
                r_k   <= 5'd0;
                r_vec <= 1'b0;
                r_job <= tuvr_pkg::JOB_FINAL;
            end
            tuvr_pkg::S_FANG: begin
                r_cx <= {{4{w_ex[31]}}, w_ex};
                r_cy <= {{4{w_ey[31]}}, w_ey};
            end
            tuvr_pkg::S_FROT: begin
                r_k   <= 5'd0;
                r_vec <= 1'b1;
                r_job <= tuvr_pkg::JOB_ANGLE;
                if (r_cx == 36'sd0 && r_cy == 36'sd0) begin
                    r_ca <= 34'sd0;
                end else if (r_cx[35]) begin
                    // quarter-turn pre-rotation into the right half plane
                    if (!r_cy[35]) begin
                        r_cx <= r_cy;
                        r_cy <= -r_cx;
                        r_ca <= tuvr_pkg::TURN_QUARTER;
                    end else begin
                        r_cx <= -r_cy;
                        r_cy <= r_cx;
                        r_ca <= -tuvr_pkg::TURN_QUARTER;
                    end
                end else begin
                    r_ca <= 34'sd0;
                end
            end
            tuvr_pkg::S_DONE: begin
                r_out.u_coord <= r_ca[30:23];
                r_out.v_coord <= r_z[23:16];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == tuvr_pkg::S_DONE);
        end
    end

    assign o_busy   = (r_state != tuvr_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

@@ design/tuvr_check.sv @@
// ----------------------------------------------------------------------------
// tuvr_check
// Port-level checks on the start/busy/strobe behavior of the ray marcher.
// ----------------------------------------------------------------------------
module tuvr_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // an accepted transaction makes the block busy with no result yet
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accepted transaction did not start work");

    // a result only shows once the work is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while still busy");

endmodule

bind tunnel_uv_raymarch tuvr_check u_tuvr_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
